/* rtl/thc_pkg.sv */
package thc_pkg;

  // Default parameter values of the top level.
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int FRAC_BITS_DEF    = 12;

  // Heading units per full circle (1/64 degree).
  localparam logic [15:0] FULL_CIRCLE = 16'd23040;

  // Configuration register indexes.
  localparam logic [2:0] REG_OFS_X = 3'd0;
  localparam logic [2:0] REG_OFS_Y = 3'd1;
  localparam logic [2:0] REG_OFS_Z = 3'd2;
  localparam logic [2:0] REG_SCL_X = 3'd3;
  localparam logic [2:0] REG_SCL_Y = 3'd4;
  localparam logic [2:0] REG_SCL_Z = 3'd5;
  localparam logic [2:0] REG_GAIN  = 3'd6;

  localparam logic [2:0] GAIN_RESET = 3'd6;

  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic               accel_new;
    logic signed [15:0] mag_x;
    logic signed [15:0] mag_y;
    logic signed [15:0] mag_z;
    logic               mag_new;
  } thc_in_t;

  typedef struct packed {
    logic [14:0] heading_deg;
    logic        degenerate;
  } thc_out_t;

  // Magnetometer gain (LSB per gauss) for the x/y axes or the z axis.
  function automatic logic [10:0] gain_lookup(input logic [2:0] g, input logic is_z);
    logic [10:0] v;
    case (g)
      3'd0:    v = is_z ? 11'd980 : 11'd1100;
      3'd1:    v = is_z ? 11'd760 : 11'd855;
      3'd2:    v = is_z ? 11'd600 : 11'd670;
      3'd3:    v = is_z ? 11'd400 : 11'd450;
      3'd4:    v = is_z ? 11'd355 : 11'd400;
      3'd5:    v = is_z ? 11'd295 : 11'd330;
      default: v = is_z ? 11'd205 : 11'd230;
    endcase
    return v;
  endfunction

  // Arctangent of 2^-i in 2^-32 turns.
  function automatic logic [31:0] atan_turns(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:    v = 32'h20000000;
      5'd1:    v = 32'h12E4051E;
      5'd2:    v = 32'h09FB385B;
      5'd3:    v = 32'h051111D4;
      5'd4:    v = 32'h028B0D43;
      5'd5:    v = 32'h0145D7E1;
      5'd6:    v = 32'h00A2F61E;
      5'd7:    v = 32'h00517C55;
      5'd8:    v = 32'h0028BE53;
      5'd9:    v = 32'h00145F2F;
      5'd10:   v = 32'h000A2F98;
      5'd11:   v = 32'h000517CC;
      5'd12:   v = 32'h00028BE6;
      5'd13:   v = 32'h000145F3;
      5'd14:   v = 32'h0000A2FA;
      5'd15:   v = 32'h0000517D;
      5'd16:   v = 32'h000028BE;
      5'd17:   v = 32'h0000145F;
      5'd18:   v = 32'h00000A30;
      5'd19:   v = 32'h00000518;
      5'd20:   v = 32'h0000028C;
      5'd21:   v = 32'h00000146;
      5'd22:   v = 32'h000000A3;
      5'd23:   v = 32'h00000051;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

/* rtl/tilt_compensated_heading.sv */
// Channel | Direction | Handshake              | Payload
// in      | input     | in_valid_i/in_stall_o   | in_data_i   (thc_in_t)
// out     | output    | out_valid_o/out_stall_i | out_data_o  (thc_out_t)
// cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// One item at a time. A sequencer drives a shift-add multiplier, a restoring
// divider and a square root unit, each one bit per cycle, then up to 29
// normalizing shifts and min(CORDIC_STEPS, 24) CORDIC steps. A zero-length
// acceleration ends the item after the square root with a degenerate result.
// Reset clears the held samples and registers and sets the gain to GAIN_RESET.
// A finished result waits in the output register; the next item is taken
// while it waits.
module tilt_compensated_heading #(
  parameter int CORDIC_STEPS = thc_pkg::CORDIC_STEPS_DEF,
  parameter int FRAC_BITS    = thc_pkg::FRAC_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  thc_pkg::thc_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output thc_pkg::thc_out_t out_data_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [2:0]        cfg_index_i,
  input  logic [15:0]       cfg_data_i
);
  import thc_pkg::*;

  localparam int ANW  = FRAC_BITS + 2;
  localparam int MBW  = (ANW > 17) ? ANW : 17;
  localparam int MCW  = $clog2(MBW);
  localparam int DNW  = (FRAC_BITS + 16 > 28) ? FRAC_BITS + 16 : 28;
  localparam int DCW  = $clog2(DNW);
  localparam int MW   = 28;
  localparam int EW   = MW + ANW + 1;
  localparam int NSTP = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;

  typedef enum logic [4:0] {
    S_IDLE, S_GAUSS, S_GAUSS_R, S_M_R, S_SQ, S_SQ_R, S_LEN, S_AN, S_AN_R,
    S_EP, S_EP_R, S_NY, S_NY_R, S_PROJ, S_ZCHK, S_NORM, S_CORD, S_HMUL, S_H_R,
    S_FIN, S_MUL, S_DIV, S_SQRT
  } state_e;

  state_e state_q, ret_q;

  logic signed [15:0]    held_accel_q [3];
  logic signed [15:0]    held_mag_q [3];
  logic signed [15:0]    ofs_q [3];
  logic signed [15:0]    scl_q [3];
  logic [2:0]            gain_q;
  logic signed [MW-1:0]  m_q [3];
  logic signed [ANW-1:0] an_q [3];
  logic signed [EW-1:0]  e_q [3];
  logic [1:0]            k_q;
  logic [2:0]            j_q;
  logic [31:0]           sq_q;
  logic [15:0]           len_q;

  // Shift-add multiplier.
  logic signed [63:0]    mcand_q, prod_q;
  logic signed [MBW-1:0] mplier_q;
  logic [MCW-1:0]        mcnt_q;

  // Restoring divider.
  logic [DNW-1:0]        dnum_q;
  logic [15:0]           dden_q, drem_q;
  logic [DCW-1:0]        dcnt_q;
  logic                  dneg_q;

  // Square root.
  logic [18:0]           srem_q;
  logic [15:0]           root_q;
  logic [3:0]            scnt_q;

  // Angle stage.
  logic signed [63:0]    x_q, y_q;
  logic [31:0]           z_q;
  logic [4:0]            ci_q;

  logic                  out_valid_q;
  logic [14:0]           res_h_q, out_h_q;
  logic                  res_deg_q, out_deg_q;

  logic                  in_acc;
  logic [10:0]           gain_sel;
  logic [16:0]           hm_ext, hm_abs, ha_ext, ha_abs;
  logic [DNW-1:0]        gauss_num, an_num;
  logic [63:0]           quo64;
  logic signed [63:0]    sgq, mul_add, x_abs, y_abs, big, xs, ys, hsum;
  logic [16:0]           div_r;
  logic                  div_ge;
  logic [18:0]           sq_rem2, sq_trial;
  logic                  sq_ge;
  logic [15:0]           hval;
  logic [14:0]           h_fin;
  logic [1:0]            ep_m, ep_a;

  // Round-half-away division of a product by 4096.
  function automatic logic signed [MW-1:0] rnd12(input logic signed [63:0] p);
    logic signed [63:0] a, q;
    a = p[63] ? -p : p;
    q = (a + 64'sd2048) >>> 12;
    return MW'(p[63] ? -q : q);
  endfunction

  assign in_acc      = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = '{heading_deg: out_h_q, degenerate: out_deg_q};

  // Operand preparation and the bit-step datapaths.
  always_comb begin
    gain_sel  = gain_lookup(gain_q, k_q == 2'd2);
    hm_ext    = 17'(held_mag_q[k_q]);
    hm_abs    = hm_ext[16] ? -hm_ext : hm_ext;
    ha_ext    = 17'(held_accel_q[k_q]);
    ha_abs    = ha_ext[16] ? -ha_ext : ha_ext;
    gauss_num = (DNW'(hm_abs) << 12) + DNW'(gain_sel >> 1);
    an_num    = (DNW'(ha_abs) << FRAC_BITS) + DNW'(len_q >> 1);
    quo64     = 64'(dnum_q);
    sgq       = dneg_q ? -$signed(quo64) : $signed(quo64);

    mul_add = '0;
    if (mplier_q[0]) begin
      mul_add = (mcnt_q == MCW'(MBW - 1)) ? -mcand_q : mcand_q;
    end

    div_r  = {drem_q, dnum_q[DNW-1]};
    div_ge = (div_r >= {1'b0, dden_q});

    sq_rem2  = {srem_q[16:0], sq_q[31:30]};
    sq_trial = {1'b0, root_q, 2'b01};
    sq_ge    = (sq_rem2 >= sq_trial);

    x_abs = x_q[63] ? -x_q : x_q;
    y_abs = y_q[63] ? -y_q : y_q;
    big   = (x_abs > y_abs) ? x_abs : y_abs;
    xs    = x_q >>> ci_q;
    ys    = y_q >>> ci_q;

    hsum  = prod_q + 64'sh8000_0000;
    hval  = hsum[47:32];
    h_fin = (hval >= FULL_CIRCLE) ? 15'd0 : hval[14:0];

    // Cross product terms: e0 = m1*a2 - m2*a1, e1 = m2*a0 - m0*a2, e2 = m0*a1 - m1*a0.
    case (j_q)
      3'd0:    begin ep_m = 2'd1; ep_a = 2'd2; end
      3'd1:    begin ep_m = 2'd2; ep_a = 2'd1; end
      3'd2:    begin ep_m = 2'd2; ep_a = 2'd0; end
      3'd3:    begin ep_m = 2'd0; ep_a = 2'd2; end
      3'd4:    begin ep_m = 2'd0; ep_a = 2'd1; end
      default: begin ep_m = 2'd1; ep_a = 2'd0; end
    endcase
  end

  // Sequencer, arithmetic units, held samples, registers and output.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ret_q       <= S_IDLE;
      for (int i = 0; i < 3; i++) begin
        held_accel_q[i] <= '0;
        held_mag_q[i]   <= '0;
        ofs_q[i]        <= '0;
        scl_q[i]        <= '0;
        m_q[i]          <= '0;
        an_q[i]         <= '0;
        e_q[i]          <= '0;
      end
      gain_q      <= GAIN_RESET;
      k_q         <= '0;
      j_q         <= '0;
      sq_q        <= '0;
      len_q       <= '0;
      mcand_q     <= '0;
      prod_q      <= '0;
      mplier_q    <= '0;
      mcnt_q      <= '0;
      dnum_q      <= '0;
      dden_q      <= '0;
      drem_q      <= '0;
      dcnt_q      <= '0;
      dneg_q      <= 1'b0;
      srem_q      <= '0;
      root_q      <= '0;
      scnt_q      <= '0;
      x_q         <= '0;
      y_q         <= '0;
      z_q         <= '0;
      ci_q        <= '0;
      out_valid_q <= 1'b0;
      res_h_q     <= '0;
      res_deg_q   <= 1'b0;
      out_h_q     <= '0;
      out_deg_q   <= 1'b0;
    end else begin
      // Configuration writes.
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_OFS_X: ofs_q[0] <= cfg_data_i;
          REG_OFS_Y: ofs_q[1] <= cfg_data_i;
          REG_OFS_Z: ofs_q[2] <= cfg_data_i;
          REG_SCL_X: scl_q[0] <= cfg_data_i;
          REG_SCL_Y: scl_q[1] <= cfg_data_i;
          REG_SCL_Z: scl_q[2] <= cfg_data_i;
          REG_GAIN:  gain_q   <= cfg_data_i[2:0];
          default:   ;
        endcase
      end

      // The output register loads a finished result, or empties when taken.
      if (state_q == S_FIN && (!out_valid_q || !out_stall_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            if (in_data_i.accel_new) begin
              held_accel_q[0] <= in_data_i.accel_x;
              held_accel_q[1] <= in_data_i.accel_y;
              held_accel_q[2] <= in_data_i.accel_z;
            end
            if (in_data_i.mag_new) begin
              held_mag_q[0] <= in_data_i.mag_x;
              held_mag_q[1] <= in_data_i.mag_y;
              held_mag_q[2] <= in_data_i.mag_z;
            end
            k_q     <= '0;
            state_q <= S_GAUSS;
          end
        end

        // Gauss = raw * 4096 / gain, rounded half away from zero.
        S_GAUSS: begin
          dnum_q  <= gauss_num;
          dden_q  <= 16'(gain_sel);
          drem_q  <= '0;
          dcnt_q  <= '0;
          dneg_q  <= held_mag_q[k_q][15];
          ret_q   <= S_GAUSS_R;
          state_q <= S_DIV;
        end
        S_GAUSS_R: begin
          mcand_q  <= sgq + 64'(ofs_q[k_q]);
          mplier_q <= MBW'(scl_q[k_q]);
          prod_q   <= '0;
          mcnt_q   <= '0;
          ret_q    <= S_M_R;
          state_q  <= S_MUL;
        end
        S_M_R: begin
          m_q[k_q] <= rnd12(prod_q);
          if (k_q == 2'd2) begin
            k_q     <= '0;
            sq_q    <= '0;
            state_q <= S_SQ;
          end else begin
            k_q     <= k_q + 2'd1;
            state_q <= S_GAUSS;
          end
        end

        // Squared length of the acceleration.
        S_SQ: begin
          mcand_q  <= 64'(held_accel_q[k_q]);
          mplier_q <= MBW'(held_accel_q[k_q]);
          prod_q   <= '0;
          mcnt_q   <= '0;
          ret_q    <= S_SQ_R;
          state_q  <= S_MUL;
        end
        S_SQ_R: begin
          sq_q <= sq_q + prod_q[31:0];
          if (k_q == 2'd2) begin
            k_q     <= '0;
            srem_q  <= '0;
            root_q  <= '0;
            scnt_q  <= '0;
            state_q <= S_SQRT;
          end else begin
            k_q     <= k_q + 2'd1;
            state_q <= S_SQ;
          end
        end
        S_LEN: begin
          len_q <= root_q;
          k_q   <= '0;
          if (root_q == '0) begin
            res_h_q   <= '0;
            res_deg_q <= 1'b1;
            state_q   <= S_FIN;
          end else begin
            state_q <= S_AN;
          end
        end

        // Normalized acceleration.
        S_AN: begin
          dnum_q  <= an_num;
          dden_q  <= len_q;
          drem_q  <= '0;
          dcnt_q  <= '0;
          dneg_q  <= held_accel_q[k_q][15];
          ret_q   <= S_AN_R;
          state_q <= S_DIV;
        end
        S_AN_R: begin
          an_q[k_q] <= ANW'(sgq);
          if (k_q == 2'd2) begin
            j_q     <= '0;
            state_q <= S_EP;
          end else begin
            k_q     <= k_q + 2'd1;
            state_q <= S_AN;
          end
        end

        // East = m x a_n, one product term at a time.
        S_EP: begin
          mcand_q  <= 64'(m_q[ep_m]);
          mplier_q <= MBW'(an_q[ep_a]);
          prod_q   <= '0;
          mcnt_q   <= '0;
          ret_q    <= S_EP_R;
          state_q  <= S_MUL;
        end
        S_EP_R: begin
          if (!j_q[0]) begin
            e_q[j_q[2:1]] <= EW'(prod_q);
          end else begin
            e_q[j_q[2:1]] <= e_q[j_q[2:1]] - EW'(prod_q);
          end
          if (j_q == 3'd5) begin
            j_q     <= '0;
            state_q <= S_NY;
          end else begin
            j_q     <= j_q + 3'd1;
            state_q <= S_EP;
          end
        end

        // North y component: a2*e0 - a0*e2, gathered in x.
        S_NY: begin
          if (j_q == 3'd0 && e_q[0] == '0 && e_q[1] == '0 && e_q[2] == '0) begin
            res_h_q   <= '0;
            res_deg_q <= 1'b1;
            state_q   <= S_FIN;
          end else begin
            mcand_q  <= 64'(e_q[(j_q == 3'd0) ? 2'd0 : 2'd2]);
            mplier_q <= MBW'(an_q[(j_q == 3'd0) ? 2'd2 : 2'd0]);
            prod_q   <= '0;
            mcnt_q   <= '0;
            ret_q    <= S_NY_R;
            state_q  <= S_MUL;
          end
        end
        S_NY_R: begin
          if (j_q == 3'd0) begin
            x_q     <= prod_q;
            j_q     <= 3'd1;
            state_q <= S_NY;
          end else begin
            x_q     <= x_q - prod_q;
            state_q <= S_PROJ;
          end
        end
        S_PROJ: begin
          x_q     <= -x_q;
          y_q     <= -(64'(e_q[1]) <<< FRAC_BITS);
          state_q <= S_ZCHK;
        end
        S_ZCHK: begin
          if (x_q == '0 && y_q == '0) begin
            res_h_q   <= '0;
            res_deg_q <= 1'b0;
            state_q   <= S_FIN;
          end else begin
            state_q <= S_NORM;
          end
        end

        // Bring the larger magnitude into [2^29, 2^30), one shift a cycle.
        S_NORM: begin
          if (big[63:30] != '0) begin
            x_q <= x_q >>> 1;
            y_q <= y_q >>> 1;
          end else if (big[63:29] == '0) begin
            x_q <= x_q <<< 1;
            y_q <= y_q <<< 1;
          end else begin
            if (x_q[63]) begin
              x_q <= -x_q;
              y_q <= -y_q;
              z_q <= 32'h8000_0000;
            end else begin
              z_q <= '0;
            end
            ci_q    <= '0;
            state_q <= S_CORD;
          end
        end

        // Vectoring CORDIC, one micro-rotation a cycle.
        S_CORD: begin
          if (!y_q[63]) begin
            x_q <= x_q + ys;
            y_q <= y_q - xs;
            z_q <= z_q + atan_turns(ci_q);
          end else begin
            x_q <= x_q - ys;
            y_q <= y_q + xs;
            z_q <= z_q - atan_turns(ci_q);
          end
          if (ci_q == 5'(NSTP - 1)) begin
            state_q <= S_HMUL;
          end else begin
            ci_q <= ci_q + 5'd1;
          end
        end
        S_HMUL: begin
          mcand_q  <= 64'(z_q);
          mplier_q <= MBW'(FULL_CIRCLE);
          prod_q   <= '0;
          mcnt_q   <= '0;
          ret_q    <= S_H_R;
          state_q  <= S_MUL;
        end
        S_H_R: begin
          res_h_q   <= h_fin;
          res_deg_q <= 1'b0;
          state_q   <= S_FIN;
        end

        // Hand the result to the output register once it is free.
        S_FIN: begin
          if (!out_valid_q || !out_stall_i) begin
            out_h_q     <= res_h_q;
            out_deg_q   <= res_deg_q;
            state_q     <= S_IDLE;
          end
        end

        // One multiplier bit a cycle; the top bit carries negative weight.
        S_MUL: begin
          prod_q   <= prod_q + mul_add;
          mcand_q  <= mcand_q <<< 1;
          mplier_q <= mplier_q >>> 1;
          mcnt_q   <= mcnt_q + MCW'(1);
          if (mcnt_q == MCW'(MBW - 1)) begin
            state_q <= ret_q;
          end
        end

        // One quotient bit a cycle; the quotient shifts into dnum.
        S_DIV: begin
          drem_q <= div_ge ? 16'(div_r - {1'b0, dden_q}) : div_r[15:0];
          dnum_q <= {dnum_q[DNW-2:0], div_ge};
          dcnt_q <= dcnt_q + DCW'(1);
          if (dcnt_q == DCW'(DNW - 1)) begin
            state_q <= ret_q;
          end
        end

        // One root bit a cycle from two radicand bits.
        S_SQRT: begin
          srem_q <= sq_ge ? (sq_rem2 - sq_trial) : sq_rem2;
          root_q <= {root_q[14:0], sq_ge};
          sq_q   <= {sq_q[29:0], 2'b00};
          scnt_q <= scnt_q + 4'd1;
          if (scnt_q == 4'd15) begin
            state_q <= S_LEN;
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

  // A degenerate result always reports heading zero.
  a_deg_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.degenerate |-> out_data_o.heading_deg == '0)
    else $error("degenerate result with nonzero heading");

  // Headings stay below a full circle.
  a_heading_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> 16'(out_data_o.heading_deg) < FULL_CIRCLE)
    else $error("heading out of range");

  // An accepted item keeps the block busy in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> in_stall_o)
    else $error("block idle right after accepting an item");

  // A result is loaded only into a free or draining output register.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_FIN && out_valid_q && out_stall_i |=> state_q == S_FIN)
    else $error("result left the sequencer while output was stalled");

  // The multiplier counter never runs past its operand width.
  a_mul_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_MUL |-> 32'(mcnt_q) < MBW)
    else $error("multiplier counter overran");

endmodule
